// ----- hw/rtl/utcl_pkg.sv -----
// Shared constants, types and helpers for the unicycle tracking control law.
`default_nettype none
package utcl_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // CORDIC settings: 16 rotations, Q2.30 datapath, angles in 2^32 per turn
    localparam int CORDIC_STEPS = 16;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER_Z = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_Z = 34'sd2147483648;

    localparam logic [1:0] ADDR_GAIN_ALONG = 2'd0;
    localparam logic [1:0] ADDR_GAIN_LATERAL = 2'd1;
    localparam logic [1:0] ADDR_GAIN_HEADING = 2'd2;

    localparam logic signed [31:0] GAIN_RESET = 32'sd65536;

    function automatic logic signed [CW-1:0] atan_entry(input logic [3:0] i);
        logic signed [CW-1:0] r;
        begin
            unique case (i)
                4'd0: r = 34'sh020000000;
                4'd1: r = 34'sh012E4051E;
                4'd2: r = 34'sh009FB385B;
                4'd3: r = 34'sh0051111D4;
                4'd4: r = 34'sh0028B0D43;
                4'd5: r = 34'sh00145D7E1;
                4'd6: r = 34'sh000A2F61E;
                4'd7: r = 34'sh000517C55;
                4'd8: r = 34'sh00028BE53;
                4'd9: r = 34'sh000145F2F;
                4'd10: r = 34'sh0000A2F98;
                4'd11: r = 34'sh0000517CC;
                4'd12: r = 34'sh000028BE6;
                4'd13: r = 34'sh0000145F3;
                4'd14: r = 34'sh000000A2FA;
                default: r = 34'sh00000517D;
            endcase
            return r;
        end
    endfunction

    // Q2.30 -> Q1.15, round half up, clamp to +-1.0
    function automatic logic signed [16:0] q15_round(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        logic signed [CW:0] r;
        begin
            t = (CW+1)'(v) + (CW+1)'(16384);
            r = t >>> 15;
            if (r > (CW+1)'(32768)) r = (CW+1)'(32768);
            if (r < -(CW+1)'(32768)) r = -(CW+1)'(32768);
            return r[16:0];
        end
    endfunction

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic flip;
    } cordic_t;

endpackage
`default_nettype wire

// ----- hw/rtl/utcl_cordic_cell.sv -----
// One CORDIC rotation cell; stage index fixed by parameter.
`default_nettype none
module utcl_cordic_cell
    import utcl_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic    aclk,
    input  wire logic    en,
    input  wire cordic_t d_in,
    output cordic_t      d_out
);
    cordic_t cell_reg;
    cordic_t cell_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;

    always_comb begin
        xs = d_in.x >>> STAGE;
        ys = d_in.y >>> STAGE;
        at = atan_entry(4'(STAGE));
        cell_next.flip = d_in.flip;
        if (d_in.z >= 0) begin
            cell_next.x = d_in.x - ys;
            cell_next.y = d_in.y + xs;
            cell_next.z = d_in.z - at;
        end else begin
            cell_next.x = d_in.x + ys;
            cell_next.y = d_in.y - xs;
            cell_next.z = d_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) cell_reg <= cell_next;
    end

    assign d_out = cell_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/utcl_sincos.sv -----
// Pipelined sine/cosine: chain of CORDIC cells plus fold and rounding.
`default_nettype none
module utcl_sincos
    import utcl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [15:0] ang,
    output logic signed [16:0]      cos_q15,
    output logic signed [16:0]      sin_q15
);
    cordic_t chain [0:CORDIC_STEPS];
    logic signed [CW-1:0] z0;
    logic signed [16:0] c;
    logic signed [16:0] s;

    always_comb begin
        z0 = CW'(ang) <<< 16;
        chain[0].x = CORDIC_GAIN_Q30;
        chain[0].y = '0;
        chain[0].flip = 1'b0;
        chain[0].z = z0;
        if (z0 > QUARTER_Z) begin
            chain[0].z = z0 - HALF_Z;
            chain[0].flip = 1'b1;
        end else if (z0 < -QUARTER_Z) begin
            chain[0].z = z0 + HALF_Z;
            chain[0].flip = 1'b1;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        utcl_cordic_cell #(.STAGE(g)) u_cell (
            .aclk(aclk), .en(en), .d_in(chain[g]), .d_out(chain[g+1])
        );
    end

    always_comb begin
        c = q15_round(chain[CORDIC_STEPS].x);
        s = q15_round(chain[CORDIC_STEPS].y);
        cos_q15 = chain[CORDIC_STEPS].flip ? -c : c;
        sin_q15 = chain[CORDIC_STEPS].flip ? -s : s;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/utcl_sqrt_cell.sv -----
// One restoring square-root cell: retires one result bit per stage.
`default_nettype none
module utcl_sqrt_cell
    import utcl_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] rem_in,
    input  wire logic [31:0] root_in,
    output logic [63:0]      rem_out,
    output logic [31:0]      root_out
);
    localparam int SH = 2 * (31 - STAGE);
    logic [63:0] rem_reg;
    logic [63:0] rem_next;
    logic [31:0] root_reg;
    logic [31:0] root_next;
    logic [65:0] trial;

    always_comb begin
        trial = ((66'(root_in) << 2) | 66'd1) << SH;
        if (66'(rem_in) >= trial) begin
            rem_next = rem_in - trial[63:0];
            root_next = {root_in[30:0], 1'b1};
        end else begin
            rem_next = rem_in;
            root_next = {root_in[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out = rem_reg;
    assign root_out = root_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/utcl_mul_sat.sv -----
// Signed product, shift toward zero and saturate, registered.
`default_nettype none
module utcl_mul_sat
    import utcl_pkg::*;
#(
    parameter int AW = 34,
    parameter int BW = 17,
    parameter int SH = 15,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [AW-1:0]     a,
    input  wire logic signed [BW-1:0]     b,
    output logic signed [WORD_BITS-1:0]   p
);
    localparam int PW = AW + BW;
    logic signed [PW-1:0] prod_reg;
    logic [PW-1:0] mag;
    logic [PW-1:0] q;
    logic neg;
    logic signed [WORD_BITS-1:0] p_reg;
    logic signed [WORD_BITS-1:0] p_next;

    always_ff @(posedge aclk) begin
        if (en) prod_reg <= PW'(a) * PW'(b);
    end

    always_comb begin
        neg = prod_reg[PW-1];
        mag = neg ? PW'(-prod_reg) : PW'(prod_reg);
        q = mag >> SH;
        if (!neg && q > PW'({1'b0, {(WORD_BITS-1){1'b1}}}))
            p_next = {1'b0, {(WORD_BITS-1){1'b1}}};
        else if (neg && q > PW'({1'b1, {(WORD_BITS-1){1'b0}}}))
            p_next = {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            p_next = neg ? WORD_BITS'(-q) : WORD_BITS'(q);
    end

    always_ff @(posedge aclk) begin
        if (en) p_reg <= p_next;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/unicycle_tracking_control_law_top.sv -----
// Top level of the unicycle tracking control law pipeline.
// Throughput: one beat per cycle; the pipeline is a chain of CORDIC and square-root cells.
// A stall on the result side freezes the whole chain (single enable, output register).
// Reset (aresetn low, synchronous) clears valid bits; gains return to 1.0 (65536).
// Datapath registers carry no reset.
`default_nettype none
module unicycle_tracking_control_law_top
    import utcl_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic signed [31:0]    s_cur_x,
    input  wire logic signed [31:0]    s_cur_y,
    input  wire logic signed [15:0]    s_cur_yaw,
    input  wire logic signed [31:0]    s_tgt_x,
    input  wire logic signed [31:0]    s_tgt_y,
    input  wire logic signed [15:0]    s_tgt_yaw,
    input  wire logic signed [31:0]    s_tgt_vel_x,
    input  wire logic signed [31:0]    s_tgt_vel_y,
    input  wire logic signed [31:0]    s_tgt_yaw_rate,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [31:0]         m_speed_cmd,
    output logic signed [31:0]         m_turn_cmd
);
    // Stage map (en = advance), counted in edges after the input beat:
    //  1..16  both sincos chains; 17..18 rotation products; 19 x,y sums
    //  1..32  square-root cells; 33 signed reference speed v
    //  34..35 gain and trig products; 36..37 (ky*v)*y
    //  38 speed and turn sums; 39..43 output delay
    localparam int DEPTH = 43;
    localparam int W = WORD_BITS;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    // ---------------- configuration ----------------
    logic signed [31:0] gain_along_reg;
    logic signed [31:0] gain_lateral_reg;
    logic signed [31:0] gain_heading_reg;
    logic [1:0] reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_along_reg <= GAIN_RESET;
            gain_lateral_reg <= GAIN_RESET;
            gain_heading_reg <= GAIN_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                ADDR_GAIN_ALONG: gain_along_reg <= pwdata;
                ADDR_GAIN_LATERAL: gain_lateral_reg <= pwdata;
                ADDR_GAIN_HEADING: gain_heading_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ADDR_GAIN_ALONG: prdata = gain_along_reg;
            ADDR_GAIN_LATERAL: prdata = gain_lateral_reg;
            ADDR_GAIN_HEADING: prdata = gain_heading_reg;
            default: prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Whole chain advances together; input flows whenever the last
    // stage is empty or its beat is being taken.
    logic [DEPTH-1:0] vld_reg;
    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
    end

    // ---------------- entry logic ----------------
    logic signed [15:0] phi_raw;
    logic signed [15:0] phi_fold;
    logic fold;
    logic signed [32:0] dx_in;
    logic signed [32:0] dy_in;
    logic [63:0] sq_in;
    logic signed [63:0] vx2;
    logic signed [63:0] vy2;

    always_comb begin
        phi_raw = s_tgt_yaw - s_cur_yaw;
        fold = (phi_raw >= 16'sd16384) || (phi_raw <= -16'sd16384);
        phi_fold = phi_raw;
        if (phi_raw >= 16'sd16384) phi_fold = phi_raw - 16'sh8000;
        else if (phi_raw <= -16'sd16384) phi_fold = phi_raw + 16'sh8000;
        dx_in = 33'(s_tgt_x) - 33'(s_cur_x);
        dy_in = 33'(s_tgt_y) - 33'(s_cur_y);
        vx2 = 64'(s_tgt_vel_x) * 64'(s_tgt_vel_x);
        vy2 = 64'(s_tgt_vel_y) * 64'(s_tgt_vel_y);
        sq_in = vx2 + vy2;
    end

    // trig chains (16 cells, rounding after the last)
    logic signed [16:0] cy, sy, cp, sp;
    utcl_sincos u_yaw (.aclk(aclk), .en(en), .ang(s_cur_yaw), .cos_q15(cy), .sin_q15(sy));
    utcl_sincos u_phi (.aclk(aclk), .en(en), .ang(phi_fold), .cos_q15(cp), .sin_q15(sp));

    // ---------------- square root chain (32 cells) ----------------
    logic [63:0] rem_c [0:32];
    logic [31:0] root_c [0:32];
    assign rem_c[0] = sq_in;
    assign root_c[0] = '0;
    for (genvar g = 0; g < 32; g++) begin : g_sqrt
        utcl_sqrt_cell #(.STAGE(g)) u_sq (
            .aclk(aclk), .en(en), .rem_in(rem_c[g]), .root_in(root_c[g]),
            .rem_out(rem_c[g+1]), .root_out(root_c[g+1])
        );
    end

    // ---------------- delay lines ----------------
    logic signed [32:0] dx_d [0:16];
    logic signed [32:0] dy_d [0:16];
    logic fold_d [0:32];
    logic signed [31:0] om_d [0:42];
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_d[0] <= dx_in;
            dy_d[0] <= dy_in;
            fold_d[0] <= fold;
            om_d[0] <= s_tgt_yaw_rate;
            for (int k = 1; k < 17; k++) begin
                dx_d[k] <= dx_d[k-1];
                dy_d[k] <= dy_d[k-1];
            end
            for (int k = 1; k < 33; k++) fold_d[k] <= fold_d[k-1];
            for (int k = 1; k < 43; k++) om_d[k] <= om_d[k-1];
        end
    end

    // rotation into robot frame: stages 17..19
    logic signed [W-1:0] p_dxc, p_dys, p_dyc, p_dxs;
    utcl_mul_sat #(.AW(33), .BW(17), .SH(15), .WORD_BITS(W)) u_m0
        (.aclk(aclk), .en(en), .a(dx_d[15]), .b(cy), .p(p_dxc));
    utcl_mul_sat #(.AW(33), .BW(17), .SH(15), .WORD_BITS(W)) u_m1
        (.aclk(aclk), .en(en), .a(dy_d[15]), .b(sy), .p(p_dys));
    utcl_mul_sat #(.AW(33), .BW(17), .SH(15), .WORD_BITS(W)) u_m2
        (.aclk(aclk), .en(en), .a(dy_d[15]), .b(cy), .p(p_dyc));
    utcl_mul_sat #(.AW(33), .BW(17), .SH(15), .WORD_BITS(W)) u_m3
        (.aclk(aclk), .en(en), .a(dx_d[15]), .b(sy), .p(p_dxs));

    function automatic logic signed [W-1:0] sat_add(input logic signed [W+1:0] s);
        logic signed [W-1:0] r;
        begin
            if (s > (W+2)'(WMAX)) r = WMAX;
            else if (s < (W+2)'(WMIN)) r = WMIN;
            else r = s[W-1:0];
            return r;
        end
    endfunction

    // x,y registered at 19; hold them until 33 (x) and 35 (y)
    logic signed [W-1:0] xr_d [0:22];
    logic signed [W-1:0] yr_d [0:22];
    logic signed [16:0] cp_d [0:16];
    logic signed [16:0] sp_d [0:16];
    always_ff @(posedge aclk) begin
        if (en) begin
            xr_d[0] <= sat_add((W+2)'(p_dxc) + (W+2)'(p_dys));
            yr_d[0] <= sat_add((W+2)'(p_dyc) - (W+2)'(p_dxs));
            for (int k = 1; k < 23; k++) begin
                xr_d[k] <= xr_d[k-1];
                yr_d[k] <= yr_d[k-1];
            end
            cp_d[0] <= cp;
            sp_d[0] <= sp;
            for (int k = 1; k < 17; k++) begin
                cp_d[k] <= cp_d[k-1];
                sp_d[k] <= sp_d[k-1];
            end
        end
    end

    // ---------------- reference speed at stage 33 ----------------
    // root_c[32] holds floor sqrt at stage 32; fold_d[31] aligns.
    logic signed [W-1:0] v_reg;
    logic signed [W-1:0] v_abs;
    always_comb begin
        if ({32'd0, root_c[32]} > 64'(WMAX)) v_abs = WMAX;
        else v_abs = W'(root_c[32]);
    end
    always_ff @(posedge aclk) begin
        if (en) v_reg <= fold_d[31] ? -v_abs : v_abs;
    end

    // stage 33: v_reg; xr_d[14] at 19+14 = 33; cp_d[16] at 17+16 = 33
    logic signed [W-1:0] p_kx, p_vc, p_kv, p_ks;
    utcl_mul_sat #(.AW(32), .BW(W), .SH(FRAC_BITS), .WORD_BITS(W)) u_m4
        (.aclk(aclk), .en(en), .a(gain_along_reg), .b(xr_d[14]), .p(p_kx));
    utcl_mul_sat #(.AW(W), .BW(17), .SH(15), .WORD_BITS(W)) u_m5
        (.aclk(aclk), .en(en), .a(v_reg), .b(cp_d[16]), .p(p_vc));
    utcl_mul_sat #(.AW(32), .BW(W), .SH(FRAC_BITS), .WORD_BITS(W)) u_m6
        (.aclk(aclk), .en(en), .a(gain_lateral_reg), .b(v_reg), .p(p_kv));
    utcl_mul_sat #(.AW(32), .BW(17), .SH(15), .WORD_BITS(W)) u_m7
        (.aclk(aclk), .en(en), .a(gain_heading_reg), .b(sp_d[16]), .p(p_ks));

    // stage 35: (ky*v)*y ; y registered at 19 -> index 16 at 35
    logic signed [W-1:0] p_kvy;
    utcl_mul_sat #(.AW(W), .BW(W), .SH(FRAC_BITS), .WORD_BITS(W)) u_m8
        (.aclk(aclk), .en(en), .a(p_kv), .b(yr_d[16]), .p(p_kvy));

    // target yaw rate saturated to the word before the sum
    logic signed [W-1:0] om_w;
    always_comb begin
        if (64'(om_d[36]) > 64'(WMAX)) om_w = WMAX;
        else if (64'(om_d[36]) < 64'(WMIN)) om_w = WMIN;
        else om_w = W'(om_d[36]);
    end

    // align speed terms (ready at 35) and heading term to 37
    logic signed [W-1:0] kx_d [0:1];
    logic signed [W-1:0] vc_d [0:1];
    logic signed [W-1:0] ks_d [0:1];
    logic signed [W-1:0] speed_reg;
    logic signed [W-1:0] turn_reg;
    logic signed [W+1:0] turn_sum;
    always_comb begin
        turn_sum = (W+2)'(om_w) + (W+2)'(p_kvy) + (W+2)'(ks_d[1]);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            kx_d[0] <= p_kx;
            kx_d[1] <= kx_d[0];
            vc_d[0] <= p_vc;
            vc_d[1] <= vc_d[0];
            ks_d[0] <= p_ks;
            ks_d[1] <= ks_d[0];
            speed_reg <= sat_add((W+2)'(kx_d[1]) + (W+2)'(vc_d[1]));
            turn_reg <= sat_add(turn_sum);
        end
    end

    // stage 38 results; delay to DEPTH
    logic signed [W-1:0] spd_d [0:4];
    logic signed [W-1:0] trn_d [0:4];
    always_ff @(posedge aclk) begin
        if (en) begin
            spd_d[0] <= speed_reg;
            trn_d[0] <= turn_reg;
            for (int k = 1; k < 5; k++) begin
                spd_d[k] <= spd_d[k-1];
                trn_d[k] <= trn_d[k-1];
            end
        end
    end
    assign m_speed_cmd = 32'(spd_d[4]);
    assign m_turn_cmd = 32'(trn_d[4]);

`ifndef SYNTH
    // a stalled result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_speed_cmd) && $stable(m_turn_cmd))
        else $error("result changed while stalled");
    // input ready follows output side only
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready mismatch");
    // an accepted beat enters the valid chain
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted beat lost");
`endif
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the unicycle tracking control law top level.
module tb;
    import utcl_pkg::*;

    // One pose/velocity beat on the input channel.
    typedef struct {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [15:0] cur_yaw;
        logic signed [31:0] tgt_x;
        logic signed [31:0] tgt_y;
        logic signed [15:0] tgt_yaw;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] yaw_rate;
    } pose_beat_t;

    // Commanded speed and turn rate for one beat.
    typedef struct {
        logic signed [31:0] speed;
        logic signed [31:0] turn;
    } drive_cmd_t;

    // Predicts the control law and holds the commands still owed by the pipeline.
    class control_law_board;
        logic signed [31:0] k_along;
        logic signed [31:0] k_lateral;
        logic signed [31:0] k_heading;
        drive_cmd_t owed[$];
        int errors;
        int checked;

        function new();
            k_along = GAIN_RESET;
            k_lateral = GAIN_RESET;
            k_heading = GAIN_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function longint clamp_word(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // exact product, magnitude truncated by sh, then saturated
        function longint prod_trunc(longint a, longint b, int sh);
            logic [127:0] mag;
            logic neg;
            neg = (a < 0) != (b < 0);
            mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
            mag = mag >> sh;
            if (neg) return (mag > 128'd2147483648) ? -64'sd2147483648 : -longint'(mag);
            return (mag > 128'd2147483647) ? 64'sd2147483647 : longint'(mag);
        endfunction

        function longint to_q15(longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 32768) r = 32768;
            if (r < -32768) r = -32768;
            return r;
        endfunction

        function longint atan_q30(int i);
            case (i)
                0: return 64'h20000000;   1: return 64'h12E4051E;
                2: return 64'h09FB385B;   3: return 64'h051111D4;
                4: return 64'h028B0D43;   5: return 64'h0145D7E1;
                6: return 64'h00A2F61E;   7: return 64'h00517C55;
                8: return 64'h0028BE53;   9: return 64'h00145F2F;
                10: return 64'h000A2F98;  11: return 64'h000517CC;
                12: return 64'h00028BE6;  13: return 64'h000145F3;
                14: return 64'h0000A2FA;  default: return 64'h0000517D;
            endcase
        endfunction

        // 16-step rotation, binary angle in, Q1.15 cos/sin out
        function void trig(longint ang, output longint c, output longint s);
            longint x, y, z, xs, ys;
            bit flip;
            x = 652032874;
            y = 0;
            z = ang * 65536;
            flip = 0;
            if (z > (64'sd1 <<< 30)) begin
                z -= 64'sd1 <<< 31;
                flip = 1;
            end else if (z < -(64'sd1 <<< 30)) begin
                z += 64'sd1 <<< 31;
                flip = 1;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_q30(i);
                end else begin
                    x += ys; y -= xs; z += atan_q30(i);
                end
            end
            c = to_q15(x);
            s = to_q15(y);
            if (flip) begin
                c = -c;
                s = -s;
            end
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function void note_beat(pose_beat_t b);
            longint dx, dy, yaw, phi, vx, vy, cy, sy, cp, sp, x, y, v;
            longint unsigned sq;
            drive_cmd_t e;
            logic signed [15:0] dphi;
            dx = longint'(b.tgt_x) - longint'(b.cur_x);
            dy = longint'(b.tgt_y) - longint'(b.cur_y);
            yaw = b.cur_yaw;
            dphi = b.tgt_yaw - b.cur_yaw;
            phi = dphi;
            vx = b.vel_x;
            vy = b.vel_y;
            trig(yaw, cy, sy);
            x = clamp_word(prod_trunc(dx, cy, 15) + prod_trunc(dy, sy, 15));
            y = clamp_word(prod_trunc(dy, cy, 15) - prod_trunc(dx, sy, 15));
            sq = longint'(vx * vx) + longint'(vy * vy);
            v = clamp_word(longint'(int_sqrt(sq)));
            if (phi >= 16384) begin
                phi -= 32768; v = -v;
            end else if (phi <= -16384) begin
                phi += 32768; v = -v;
            end
            v = clamp_word(v);
            trig(phi, cp, sp);
            e.speed = 32'(clamp_word(prod_trunc(k_along, x, 16) + prod_trunc(v, cp, 15)));
            e.turn = 32'(clamp_word(longint'(b.yaw_rate)
                + prod_trunc(prod_trunc(k_lateral, v, 16), y, 16)
                + prod_trunc(k_heading, sp, 15)));
            owed.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH beat %0d %s: got %h want %h", checked, what, got, want);
            errors++;
        endtask

        task check_cmd(logic signed [31:0] speed, logic signed [31:0] turn);
            drive_cmd_t e;
            if (owed.size() == 0) begin
                report("unexpected result", speed, '0);
            end else begin
                e = owed.pop_front();
                if (speed !== e.speed) report("speed_cmd", speed, e.speed);
                if (turn !== e.turn) report("turn_cmd", turn, e.turn);
            end
            checked++;
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 0;
    logic s_ready;
    logic signed [31:0] s_cur_x = 0, s_cur_y = 0, s_tgt_x = 0, s_tgt_y = 0;
    logic signed [15:0] s_cur_yaw = 0, s_tgt_yaw = 0;
    logic signed [31:0] s_tgt_vel_x = 0, s_tgt_vel_y = 0, s_tgt_yaw_rate = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_speed_cmd, m_turn_cmd;

    control_law_board board = new();
    bit calm = 0;   // phase with no gaps or stalls

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    unicycle_tracking_control_law_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cur_x(s_cur_x), .s_cur_y(s_cur_y), .s_cur_yaw(s_cur_yaw),
        .s_tgt_x(s_tgt_x), .s_tgt_y(s_tgt_y), .s_tgt_yaw(s_tgt_yaw),
        .s_tgt_vel_x(s_tgt_vel_x), .s_tgt_vel_y(s_tgt_vel_y),
        .s_tgt_yaw_rate(s_tgt_yaw_rate),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_speed_cmd(m_speed_cmd), .m_turn_cmd(m_turn_cmd)
    );

    // APB write: setup, access; register lands on the access edge
    task gain_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            ADDR_GAIN_ALONG: board.k_along = val;
            ADDR_GAIN_LATERAL: board.k_lateral = val;
            default: board.k_heading = val;
        endcase
    endtask

    // mostly meter-scale values, with full-range words and the two extremes mixed in
    function logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h000A_0000))) - 32'h0005_0000;
        endcase
    endfunction

    function logic [31:0] pick_gain();
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function pose_beat_t random_beat();
        pose_beat_t b;
        b.cur_x = pick_word(); b.cur_y = pick_word();
        b.tgt_x = pick_word(); b.tgt_y = pick_word();
        b.vel_x = pick_word(); b.vel_y = pick_word();
        b.yaw_rate = pick_word();
        b.cur_yaw = 16'($urandom);
        // land the heading error on the fold boundaries now and then
        case ($urandom_range(0, 7))
            0: b.tgt_yaw = b.cur_yaw + 16'sd16384;
            1: b.tgt_yaw = b.cur_yaw - 16'sd16384;
            2: b.tgt_yaw = b.cur_yaw + 16'h8000;
            default: b.tgt_yaw = 16'($urandom);
        endcase
        return b;
    endfunction

    task send_beat(pose_beat_t b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_cur_x <= b.cur_x; s_cur_y <= b.cur_y; s_cur_yaw <= b.cur_yaw;
        s_tgt_x <= b.tgt_x; s_tgt_y <= b.tgt_y; s_tgt_yaw <= b.tgt_yaw;
        s_tgt_vel_x <= b.vel_x; s_tgt_vel_y <= b.vel_y; s_tgt_yaw_rate <= b.yaw_rate;
        do @(posedge aclk); while (!s_ready);
        board.note_beat(b);
    endtask

    task drain();
        s_valid <= 0;
        @(posedge aclk);
        while (board.owed.size() != 0) @(posedge aclk);
    endtask

    function pose_beat_t directed_beat(int n);
        pose_beat_t b;
        b = '{default: 0};
        b.vel_x = 32'sh0001_0000;
        case (n)
            0: ;
            1: begin b.tgt_x = 32'h7FFF_FFFF; b.cur_x = 32'h8000_0000; end
            2: begin b.tgt_y = 32'h8000_0000; b.cur_y = 32'h7FFF_FFFF; end
            3: begin b.vel_x = 32'h8000_0000; b.vel_y = 32'h8000_0000; end
            4: begin b.vel_x = 32'h7FFF_FFFF; b.vel_y = 32'h0; end
            5: b.tgt_yaw = 16'sd16384;                      // fold at +90
            6: b.tgt_yaw = -16'sd16384;                     // fold at -90
            7: b.tgt_yaw = 16'h8000;                        // fold at 180
            8: b.tgt_yaw = 16'sd16383;
            9: b.tgt_yaw = -16'sd16383;
            10: begin b.cur_yaw = 16'h8000; b.tgt_x = 32'sh0003_0000; end
            11: begin b.cur_yaw = 16'sh7FFF; b.tgt_yaw = 16'h8000; end
            12: begin b.cur_yaw = 16'sd16384; b.tgt_y = 32'sh0002_0000; end
            13: begin b.cur_yaw = -16'sd16384; b.tgt_x = 32'sh0001_8000; end
            14: b.yaw_rate = 32'h7FFF_FFFF;
            15: b.yaw_rate = 32'h8000_0000;
            16: begin
                b.tgt_x = 32'h7FFF_FFFF; b.tgt_y = 32'h7FFF_FFFF;
                b.cur_x = 32'h8000_0000; b.cur_y = 32'h8000_0000;
                b.cur_yaw = 16'sd8192; b.yaw_rate = 32'h7FFF_FFFF;
            end
            17: begin
                b.cur_x = 32'hFFFF_FFFF; b.cur_y = 32'hFFFF_FFFF;
                b.vel_x = 32'hFFFF_FFFF; b.vel_y = 32'hFFFF_FFFF;
                b.cur_yaw = 16'hFFFF; b.tgt_yaw = 16'hFFFF; b.yaw_rate = 32'hFFFF_FFFF;
            end
            default: begin
                b.tgt_x = 32'h5555_5555; b.tgt_y = 32'hAAAA_AAAA;
                b.cur_yaw = 16'h5555; b.tgt_yaw = 16'hAAAA;
            end
        endcase
        return b;
    endfunction

    // result side: random stall before each beat outside calm phases
    initial begin
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            board.check_cmd(m_speed_cmd, m_turn_cmd);
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // directed beats at reset gains, then at extreme gains
        for (int n = 0; n < 19; n++) send_beat(directed_beat(n));
        drain();
        gain_write(ADDR_GAIN_ALONG, 32'h7FFF_FFFF);
        gain_write(ADDR_GAIN_LATERAL, 32'h8000_0000);
        gain_write(ADDR_GAIN_HEADING, 32'h7FFF_FFFF);
        for (int n = 0; n < 6; n++) send_beat(directed_beat(n * 3));
        drain();

        // random phases, each with fresh gains; some phases run without gaps
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    gain_write(ADDR_GAIN_ALONG, 32'h8000_0000);
                    gain_write(ADDR_GAIN_LATERAL, 32'h7FFF_FFFF);
                    gain_write(ADDR_GAIN_HEADING, 32'h8000_0000);
                end
                1: begin
                    gain_write(ADDR_GAIN_ALONG, 32'h0);
                    gain_write(ADDR_GAIN_LATERAL, 32'h0);
                    gain_write(ADDR_GAIN_HEADING, 32'h0);
                end
                2: begin
                    gain_write(ADDR_GAIN_ALONG, GAIN_RESET);
                    gain_write(ADDR_GAIN_LATERAL, GAIN_RESET);
                    gain_write(ADDR_GAIN_HEADING, GAIN_RESET);
                end
                default: begin
                    gain_write(ADDR_GAIN_ALONG, pick_gain());
                    gain_write(ADDR_GAIN_LATERAL, pick_gain());
                    gain_write(ADDR_GAIN_HEADING, pick_gain());
                end
            endcase
            calm = (ph % 4 == 3);
            for (int n = 0; n < 93; n++) send_beat(random_beat());
            drain();
        end

        repeat (60) @(posedge aclk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/utcl_pkg.sv
hw/rtl/utcl_cordic_cell.sv
hw/rtl/utcl_sincos.sv
hw/rtl/utcl_sqrt_cell.sv
hw/rtl/utcl_mul_sat.sv
hw/rtl/unicycle_tracking_control_law_top.sv
tb/tb.sv
